@@ hdl/svpg_pkg.sv @@
`timescale 1ns / 1ps

package svpg_pkg;

    localparam int IDX_W     = 12;
    localparam int AREA_W    = 12;
    localparam int RAD_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int GEO_W     = 13;
    localparam int TRIG_W    = 20;
    localparam int ANG_W     = 34;
    localparam int PROD_W    = GEO_W + TRIG_W;
    localparam int SUM_W     = 36;
    localparam int FRAC_W    = 16;
    localparam int MARGIN    = 10;
    localparam int ATAN_LEN  = 24;
    localparam int CORDIC_X0 = 39797;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAPE_MODE  = 3'd0,
        CFG_AREA_WIDTH  = 3'd1,
        CFG_AREA_HEIGHT = 3'd2,
        CFG_POINT_COUNT = 3'd3,
        CFG_STAR_INNER  = 3'd4,
        CFG_STAR_OUTER  = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        SHAPE_CIRCLE  = 2'd0,
        SHAPE_ELLIPSE = 2'd1,
        SHAPE_STAR    = 2'd2
    } shape_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic [1:0]               quad;
        logic                     odd;
    } cordic_data_t;

    typedef struct packed {
        logic signed [GEO_W-1:0] xc;
        logic signed [GEO_W-1:0] yc;
        logic signed [GEO_W-1:0] rx_even;
        logic signed [GEO_W-1:0] ry_even;
        logic signed [GEO_W-1:0] rx_odd;
        logic signed [GEO_W-1:0] ry_odd;
    } geometry_t;

    // Arctangent of 2^-i as a 32-bit fraction of one turn.
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10680862;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335086;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41721;
            15:      v = 32'd20860;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2607;
            19:      v = 32'd1303;
            20:      v = 32'd651;
            21:      v = 32'd325;
            22:      v = 32'd162;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/svpg_div_cell.sv @@
`timescale 1ns / 1ps

module svpg_div_cell #(
    parameter int PHASE_BITS = 16,
    parameter int BIT_POS    = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [svpg_pkg::IDX_W-1:0]  count,
    input  logic                        valid_in,
    input  logic [svpg_pkg::IDX_W-1:0]  idx_in,
    input  logic [svpg_pkg::IDX_W-1:0]  rem_in,
    input  logic [PHASE_BITS-1:0]       quo_in,
    output logic                        valid_out,
    output logic [svpg_pkg::IDX_W-1:0]  idx_out,
    output logic [svpg_pkg::IDX_W-1:0]  rem_out,
    output logic [PHASE_BITS-1:0]       quo_out
);
    import svpg_pkg::*;

    logic                 dbit;
    logic [IDX_W:0]       trial;
    logic [IDX_W:0]       diff;
    logic                 ge;
    logic                 valid_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     rem_reg;
    logic [IDX_W-1:0]     rem_next;
    logic [PHASE_BITS-1:0] quo_reg;
    logic [PHASE_BITS-1:0] quo_next;

    // The dividend is the index followed by PHASE_BITS zero bits.
    generate
        if (BIT_POS >= PHASE_BITS) begin : g_idx_bit
            assign dbit = idx_in[BIT_POS-PHASE_BITS];
        end else begin : g_zero_bit
            assign dbit = 1'b0;
        end
    endgenerate

    always_comb
    begin
        trial    = {rem_in, dbit};
        diff     = trial - {1'b0, count};
        ge       = (trial >= {1'b0, count});
        rem_next = ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
        quo_next = {quo_in[PHASE_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg <= idx_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign valid_out = valid_reg;
    assign idx_out   = idx_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

@@ hdl/svpg_cordic_cell.sv @@
`timescale 1ns / 1ps

module svpg_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  svpg_pkg::cordic_data_t data_in,
    output logic                   valid_out,
    output svpg_pkg::cordic_data_t data_out
);
    import svpg_pkg::*;

    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [ANG_W-1:0]  atan;
    cordic_data_t             data_next;
    cordic_data_t             data_reg;
    logic                     valid_reg;

    always_comb
    begin
        dx   = $signed(data_in.y) >>> STAGE;
        dy   = $signed(data_in.x) >>> STAGE;
        atan = $signed({{(ANG_W-32){1'b0}}, atan_turn(STAGE)});
        data_next = data_in;
        if (!data_in.z[ANG_W-1])
        begin
            data_next.x = $signed(data_in.x) - dx;
            data_next.y = $signed(data_in.y) + dy;
            data_next.z = $signed(data_in.z) - atan;
        end
        else
        begin
            data_next.x = $signed(data_in.x) + dx;
            data_next.y = $signed(data_in.y) - dy;
            data_next.z = $signed(data_in.z) + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ hdl/svpg_coord_out.sv @@
`timescale 1ns / 1ps

module svpg_coord_out #(
    parameter int COORD_BITS = 13
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  svpg_pkg::geometry_t     geo,
    input  logic                    valid_in,
    input  svpg_pkg::cordic_data_t  data_in,
    output logic                    valid_out,
    output logic [COORD_BITS-1:0]   x_coord,
    output logic [COORD_BITS-1:0]   y_coord
);
    import svpg_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(64'sd1 <<< (COORD_BITS - 1)));

    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [GEO_W-1:0]  rx;
    logic signed [GEO_W-1:0]  ry;
    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] py_next;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic                     mul_valid_reg;
    logic signed [SUM_W-1:0]  sx;
    logic signed [SUM_W-1:0]  sy;
    logic signed [SUM_W-1:0]  tx;
    logic signed [SUM_W-1:0]  ty;
    logic [COORD_BITS-1:0]    x_next;
    logic [COORD_BITS-1:0]    y_next;
    logic [COORD_BITS-1:0]    x_reg;
    logic [COORD_BITS-1:0]    y_reg;
    logic                     valid_reg;

    function automatic logic [COORD_BITS-1:0] saturate(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[COORD_BITS-1:0];
    endfunction

    // Quadrant rotation and radius scaling.
    always_comb
    begin
        case (data_in.quad)
            2'd0:
            begin
                cos_v = data_in.x;
                sin_v = data_in.y;
            end
            2'd1:
            begin
                cos_v = -data_in.y;
                sin_v = data_in.x;
            end
            2'd2:
            begin
                cos_v = -data_in.x;
                sin_v = -data_in.y;
            end
            default:
            begin
                cos_v = data_in.y;
                sin_v = -data_in.x;
            end
        endcase
        rx = data_in.odd ? geo.rx_odd : geo.rx_even;
        ry = data_in.odd ? geo.ry_odd : geo.ry_even;
        px_next = PROD_W'(rx) * PROD_W'(cos_v);
        py_next = PROD_W'(ry) * PROD_W'(sin_v);
    end

    // Centre offset, truncation toward zero and saturation.
    always_comb
    begin
        sx = (SUM_W'(geo.xc) <<< FRAC_W) + SUM_W'(px_reg);
        sy = (SUM_W'(geo.yc) <<< FRAC_W) + SUM_W'(py_reg);
        if (sx[SUM_W-1])
        begin
            sx = sx + SUM_W'((64'sd1 <<< FRAC_W) - 64'sd1);
        end
        if (sy[SUM_W-1])
        begin
            sy = sy + SUM_W'((64'sd1 <<< FRAC_W) - 64'sd1);
        end
        tx = sx >>> FRAC_W;
        ty = sy >>> FRAC_W;
        x_next = saturate(tx);
        y_next = saturate(ty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= valid_in;
            valid_reg     <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            x_reg  <= x_next;
            y_reg  <= y_next;
        end
    end

    assign valid_out = valid_reg;
    assign x_coord   = x_reg;
    assign y_coord   = y_reg;

endmodule

@@ hdl/shape_vertex_point_generator_top.sv @@
`timescale 1ns / 1ps

// Vertex generator for circles, ellipses and two-radius stars. Each point index
// transferred in yields one (x_coord, y_coord) transfer out, in order. The block
// is a single pipeline that takes one index per cycle unless the output is
// stalled: one divider cell per quotient bit turns the index into a phase,
// one CORDIC cell per rotation step produces cosine and sine, and two final
// stages scale, offset and saturate. A stalled output freezes the whole
// pipeline, so in_stall follows out_stall while a result is waiting.
// Configuration registers may only be written while no item is in flight;
// cfg_ready is always high.
module shape_vertex_point_generator_top #(
    parameter int PHASE_BITS    = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_BITS    = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [svpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [svpg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [svpg_pkg::IDX_W-1:0]        point_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COORD_BITS-1:0]      x_coord,
    output logic signed [COORD_BITS-1:0]      y_coord
);
    import svpg_pkg::*;

    localparam int DIV_STAGES = IDX_W + PHASE_BITS;

    logic [1:0]        shape_mode_reg;
    logic [AREA_W-1:0] area_width_reg;
    logic [AREA_W-1:0] area_height_reg;
    logic [IDX_W-1:0]  point_count_reg;
    logic [RAD_W-1:0]  star_inner_reg;
    logic [RAD_W-1:0]  star_outer_reg;

    logic en;

    logic                  div_valid [0:DIV_STAGES];
    logic [IDX_W-1:0]      div_idx   [0:DIV_STAGES];
    logic [IDX_W-1:0]      div_rem   [0:DIV_STAGES];
    logic [PHASE_BITS-1:0] div_quo   [0:DIV_STAGES];

    logic                  cor_valid [0:CORDIC_STAGES];
    cordic_data_t          cor_data  [0:CORDIC_STAGES];

    logic [PHASE_BITS-1:0] phase;
    logic [31:0]           angle;
    logic [29:0]           resid;

    logic signed [GEO_W-1:0] wd;
    logic signed [GEO_W-1:0] ht;
    geometry_t               geo;
    logic signed [GEO_W-1:0] rmin;
    logic [COORD_BITS-1:0]   x_raw;
    logic [COORD_BITS-1:0]   y_raw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg  <= SHAPE_CIRCLE;
            area_width_reg  <= AREA_W'(400);
            area_height_reg <= AREA_W'(400);
            point_count_reg <= IDX_W'(16);
            star_inner_reg  <= RAD_W'(50);
            star_outer_reg  <= RAD_W'(100);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SHAPE_MODE:  shape_mode_reg  <= cfg_data[1:0];
                CFG_AREA_WIDTH:  area_width_reg  <= cfg_data[AREA_W-1:0];
                CFG_AREA_HEIGHT: area_height_reg <= cfg_data[AREA_W-1:0];
                CFG_POINT_COUNT: point_count_reg <= cfg_data[IDX_W-1:0];
                CFG_STAR_INNER:  star_inner_reg  <= cfg_data[RAD_W-1:0];
                CFG_STAR_OUTER:  star_outer_reg  <= cfg_data[RAD_W-1:0];
                default:         ;
            endcase
        end
    end

    // Shape geometry depends only on the registers; the user must keep them stable
    // while items are in flight, as the block itself does not enforce this.
    always_comb
    begin
        wd = $signed({1'b0, area_width_reg}) - GEO_W'(MARGIN);
        ht = $signed({1'b0, area_height_reg}) - GEO_W'(MARGIN);
        geo.xc = (wd + $signed({{(GEO_W-1){1'b0}}, wd[GEO_W-1]})) >>> 1;
        geo.yc = (ht + $signed({{(GEO_W-1){1'b0}}, ht[GEO_W-1]})) >>> 1;
        rmin = ((wd < ht) ? geo.xc : geo.yc) - GEO_W'(MARGIN);
        case (shape_mode_reg)
            SHAPE_ELLIPSE:
            begin
                geo.rx_even = geo.xc - GEO_W'(MARGIN);
                geo.ry_even = geo.yc - GEO_W'(MARGIN);
                geo.rx_odd  = geo.rx_even;
                geo.ry_odd  = geo.ry_even;
            end
            SHAPE_STAR:
            begin
                geo.rx_even = $signed({2'b00, star_outer_reg});
                geo.ry_even = geo.rx_even;
                geo.rx_odd  = $signed({2'b00, star_inner_reg});
                geo.ry_odd  = geo.rx_odd;
            end
            default:
            begin
                geo.rx_even = rmin;
                geo.ry_even = rmin;
                geo.rx_odd  = rmin;
                geo.ry_odd  = rmin;
            end
        endcase
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign div_valid[0] = in_valid;
    assign div_idx[0]   = point_index;
    assign div_rem[0]   = '0;
    assign div_quo[0]   = '0;

    generate
        for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
            svpg_div_cell #(
                .PHASE_BITS (PHASE_BITS),
                .BIT_POS    (DIV_STAGES - 1 - k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .count     (point_count_reg),
                .valid_in  (div_valid[k]),
                .idx_in    (div_idx[k]),
                .rem_in    (div_rem[k]),
                .quo_in    (div_quo[k]),
                .valid_out (div_valid[k+1]),
                .idx_out   (div_idx[k+1]),
                .rem_out   (div_rem[k+1]),
                .quo_out   (div_quo[k+1])
            );
        end
    endgenerate

    // A residual of an eighth turn or more rotates into the next quadrant.
    always_comb
    begin
        phase = (point_count_reg == '0) ? '0 : div_quo[DIV_STAGES];
        angle = {phase, {(32 - PHASE_BITS){1'b0}}};
        resid = angle[29:0];
        cor_data[0].x   = TRIG_W'(CORDIC_X0);
        cor_data[0].y   = '0;
        cor_data[0].odd = div_idx[DIV_STAGES][0];
        if (resid[29])
        begin
            cor_data[0].quad = angle[31:30] + 2'd1;
            cor_data[0].z    = $signed({{(ANG_W-30){1'b0}}, resid}) - (ANG_W'(1) <<< 30);
        end
        else
        begin
            cor_data[0].quad = angle[31:30];
            cor_data[0].z    = $signed({{(ANG_W-30){1'b0}}, resid});
        end
    end

    assign cor_valid[0] = div_valid[DIV_STAGES];

    generate
        for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
            svpg_cordic_cell #(
                .STAGE (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .valid_in  (cor_valid[k]),
                .data_in   (cor_data[k]),
                .valid_out (cor_valid[k+1]),
                .data_out  (cor_data[k+1])
            );
        end
    endgenerate

    svpg_coord_out #(
        .COORD_BITS (COORD_BITS)
    ) u_coord_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .geo       (geo),
        .valid_in  (cor_valid[CORDIC_STAGES]),
        .data_in   (cor_data[CORDIC_STAGES]),
        .valid_out (out_valid),
        .x_coord   (x_raw),
        .y_coord   (y_raw)
    );

    assign x_coord = $signed(x_raw);
    assign y_coord = $signed(y_raw);

endmodule
